[rtl/core/monotone_chain_convex_hull_macros.svh]
// ----------------------------------------------------------------------------
// monotone_chain_convex_hull_macros
// Assertion macros shared by the hull RTL.
// ----------------------------------------------------------------------------
`ifndef MONOTONE_CHAIN_CONVEX_HULL_MACROS_SVH
`define MONOTONE_CHAIN_CONVEX_HULL_MACROS_SVH

// Implication checked every clock, muted during reset
`define MCH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, muted during reset
`define MCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mch_pkg.sv]
// ----------------------------------------------------------------------------
// mch_pkg
// Shared widths, point type and the turn-test operand struct for the hull block.
// ----------------------------------------------------------------------------
package mch_pkg;
	localparam int MAX_POINTS = 32;
	localparam int COORD_BITS = 16;
	localparam int IDX_BITS   = $clog2(MAX_POINTS);
	localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
	localparam int STK_DEPTH  = 2 * MAX_POINTS;
	localparam int STK_BITS   = $clog2(STK_DEPTH);
	localparam int TOP_BITS   = $clog2(STK_DEPTH + 1);
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} point_t;

	// Operands for the shared turn test: o -> a -> b
	typedef struct packed {
		point_t o;
		point_t a;
		point_t b;
	} turn_req_t;
endpackage

[rtl/core/mch_turn_unit.sv]
// ----------------------------------------------------------------------------
// mch_turn_unit
// Shared cross product unit: one multiplier used twice per request; the
// differences, then the first product, are registered before done and not_ccw.
// ----------------------------------------------------------------------------
module mch_turn_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mch_pkg::turn_req_t  req,
	output logic                done,
	output logic                not_ccw
);
	logic signed [mch_pkg::DIFF_BITS-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [mch_pkg::PROD_BITS-1:0] left_q;
	logic                                 phase_q;
	logic signed [mch_pkg::DIFF_BITS-1:0] m_a, m_b;
	logic signed [mch_pkg::PROD_BITS-1:0] prod;

	function automatic logic signed [mch_pkg::DIFF_BITS-1:0] DIFF_W(
		input logic signed [mch_pkg::COORD_BITS-1:0] v);
		DIFF_W = mch_pkg::DIFF_BITS'(v);
	endfunction

	// One multiplier: (a.x-o.x)*(b.y-o.y) first, (a.y-o.y)*(b.x-o.x) second
	always_comb begin
		m_a = phase_q ? ay_q : ax_q;
		m_b = phase_q ? bx_q : by_q;
		prod = m_a * m_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			done    <= 1'b0;
			not_ccw <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				ax_q    <= DIFF_W(req.a.x) - DIFF_W(req.o.x);
				ay_q    <= DIFF_W(req.a.y) - DIFF_W(req.o.y);
				bx_q    <= DIFF_W(req.b.x) - DIFF_W(req.o.x);
				by_q    <= DIFF_W(req.b.y) - DIFF_W(req.o.y);
				phase_q <= 1'b0;
			end else if (!phase_q && !done) begin
				left_q  <= prod;
				phase_q <= 1'b1;
			end else if (phase_q) begin
				not_ccw <= (left_q <= prod);
				done    <= 1'b1;
				phase_q <= 1'b0;
			end
		end
	end
endmodule

[rtl/core/monotone_chain_convex_hull.sv]
// ----------------------------------------------------------------------------
// monotone_chain_convex_hull
// Convex hull of a point set by the monotone chain method.
// ----------------------------------------------------------------------------
// Usage: present point_x/point_y/last_point with start while busy is low; the
// request is taken at that rising edge. A point beyond MAX_POINTS is dropped
// and busy stays low unless it is flagged last_point; the point flagged
// last_point closes the set. A stored point is inserted into a sorted store
// one shift per cycle, each larger point held moving up before the key lands.
// The hull pass then walks the sorted points: each step of the lower walk
// (N points) and the upper walk (N - 1 points) reads the point and the stack
// top, then waits on the shared multiplier for each turn test it issues;
// a step runs one test per pop and at most one that keeps the point.
// Results then leave one per cycle on hull_x/hull_y with strobe valid, the
// final one with hull_last, the first vertex repeated at the end when the
// set holds more than one point. The receiver cannot stall, so each result
// shows for exactly one cycle. busy drops in the cycle that carries the final
// result; the next request may be taken at the edge that ends it. One set is
// in flight at a time. Reset clears the point count and stack depth; the
// stores need no clearing because only written entries are used.
// ----------------------------------------------------------------------------
`include "monotone_chain_convex_hull_macros.svh"
module monotone_chain_convex_hull (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [mch_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [mch_pkg::COORD_BITS-1:0] point_y,
	input  logic                                  last_point,
	output logic                                  valid,
	output logic signed [mch_pkg::COORD_BITS-1:0] hull_x,
	output logic signed [mch_pkg::COORD_BITS-1:0] hull_y,
	output logic                                  hull_last
);
	typedef enum logic [3:0] {
		S_IDLE, S_INS, S_LOW_RD, S_LOW_TEST, S_LOW_WAIT, S_UP_RD, S_UP_TEST,
		S_UP_WAIT, S_OUT
	} state_t;

	state_t                           state_q;
	mch_pkg::point_t                  store_q [mch_pkg::MAX_POINTS];
	mch_pkg::point_t                  stack_q [mch_pkg::STK_DEPTH];
	logic [mch_pkg::CNT_BITS-1:0]     count_q;
	logic [mch_pkg::IDX_BITS-1:0]     pos_q;
	mch_pkg::point_t                  key_q;
	logic                             close_q;
	logic [mch_pkg::CNT_BITS-1:0]     i_q;
	logic [mch_pkg::TOP_BITS-1:0]     top_q;
	logic [mch_pkg::TOP_BITS-1:0]     lim_q;
	logic                             pass_q;
	mch_pkg::point_t                  cur_q, s1_q, s2_q;
	logic                             t_start;
	mch_pkg::turn_req_t               t_req;
	logic                             t_done, t_not_ccw;

	assign busy = (state_q != S_IDLE);
	assign t_req = '{o: s2_q, a: s1_q, b: cur_q};

	mch_turn_unit u_turn (
		.clk(clk), .arst_n(arst_n), .start(t_start), .req(t_req),
		.done(t_done), .not_ccw(t_not_ccw)
	);

	function automatic logic pt_less(input mch_pkg::point_t a, input mch_pkg::point_t b);
		pt_less = (a.x < b.x) || (a.x == b.x && a.y < b.y);
	endfunction

	// a test needs two stacked points and top_q >= lim_q, and none after a keep
	assign t_start = (state_q == S_LOW_TEST || state_q == S_UP_TEST) && (top_q >= lim_q)
		&& (top_q >= mch_pkg::TOP_BITS'(2)) && !pass_q;

	// Sequencer: insertion, lower hull, upper hull, output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			top_q     <= '0;
			pass_q    <= 1'b0;
			valid     <= 1'b0;
			hull_last <= 1'b0;
		end else begin
			valid     <= 1'b0;
			hull_last <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						close_q <= last_point;
						key_q   <= '{x: point_x, y: point_y};
						if (count_q < mch_pkg::CNT_BITS'(mch_pkg::MAX_POINTS)) begin
							pos_q   <= count_q[mch_pkg::IDX_BITS-1:0];
							count_q <= count_q + mch_pkg::CNT_BITS'(1);
							state_q <= S_INS;
						end else if (last_point) begin
							i_q     <= '0;
							top_q   <= '0;
							state_q <= S_LOW_RD;
						end
					end
				end
				S_INS: begin
					// shift one larger entry up per cycle, then drop the key in
					if (pos_q != '0
						&& pt_less(key_q, store_q[pos_q - mch_pkg::IDX_BITS'(1)])) begin
						store_q[pos_q] <= store_q[pos_q - mch_pkg::IDX_BITS'(1)];
						pos_q <= pos_q - mch_pkg::IDX_BITS'(1);
					end else begin
						store_q[pos_q] <= key_q;
						if (close_q) begin
							i_q     <= '0;
							top_q   <= '0;
							state_q <= S_LOW_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_LOW_RD, S_UP_RD: begin
					cur_q  <= store_q[i_q[mch_pkg::IDX_BITS-1:0]];
					pass_q <= 1'b0;
					if (top_q >= mch_pkg::TOP_BITS'(2)) begin
						s1_q <= stack_q[mch_pkg::STK_BITS'(top_q - mch_pkg::TOP_BITS'(1))];
						s2_q <= stack_q[mch_pkg::STK_BITS'(top_q - mch_pkg::TOP_BITS'(2))];
					end
					if (state_q == S_LOW_RD) begin
						lim_q   <= '0;
						state_q <= S_LOW_TEST;
					end else begin
						state_q <= S_UP_TEST;
					end
				end
				S_LOW_TEST, S_UP_TEST: begin
					if (t_start) begin
						state_q <= (state_q == S_LOW_TEST) ? S_LOW_WAIT : S_UP_WAIT;
					end else begin
						// push current point and advance
						if (top_q < mch_pkg::TOP_BITS'(mch_pkg::STK_DEPTH)) begin
							stack_q[mch_pkg::STK_BITS'(top_q)] <= cur_q;
							top_q <= top_q + mch_pkg::TOP_BITS'(1);
						end
						if (state_q == S_LOW_TEST) begin
							if (i_q + mch_pkg::CNT_BITS'(1) < count_q) begin
								i_q     <= i_q + mch_pkg::CNT_BITS'(1);
								state_q <= S_LOW_RD;
							end else if (count_q > mch_pkg::CNT_BITS'(1)) begin
								i_q     <= count_q - mch_pkg::CNT_BITS'(2);
								lim_q   <= top_q + mch_pkg::TOP_BITS'(2);
								state_q <= S_UP_RD;
							end else begin
								i_q     <= '0;
								state_q <= S_OUT;
							end
						end else begin
							if (i_q != '0) begin
								i_q     <= i_q - mch_pkg::CNT_BITS'(1);
								state_q <= S_UP_RD;
							end else begin
								state_q <= S_OUT;
							end
						end
					end
				end
				S_LOW_WAIT, S_UP_WAIT: begin
					if (t_done) begin
						if (t_not_ccw) begin
							top_q <= top_q - mch_pkg::TOP_BITS'(1);
						end else begin
							pass_q <= 1'b1;
						end
						state_q <= (state_q == S_LOW_WAIT) ? S_LOW_TEST : S_UP_TEST;
						if (t_not_ccw) begin
							s1_q <= s2_q;
							s2_q <= stack_q[mch_pkg::STK_BITS'(top_q - mch_pkg::TOP_BITS'(3))];
						end
					end
				end
				S_OUT: begin
					// emit stack bottom-up, capped at MAX_POINTS + 1
					valid  <= 1'b1;
					hull_x <= stack_q[mch_pkg::STK_BITS'(i_q)].x;
					hull_y <= stack_q[mch_pkg::STK_BITS'(i_q)].y;
					if (mch_pkg::TOP_BITS'(i_q) + mch_pkg::TOP_BITS'(1) >= top_q
						|| i_q == mch_pkg::CNT_BITS'(mch_pkg::MAX_POINTS)) begin
						hull_last <= 1'b1;
						count_q   <= '0;
						top_q     <= '0;
						state_q   <= S_IDLE;
					end else begin
						i_q <= i_q + mch_pkg::CNT_BITS'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MCH_ASSERT_IMPL(a_last_has_valid, clk, arst_n, hull_last, valid, "hull_last without valid")
	`MCH_ASSERT_IMPL(a_done_to_idle, clk, arst_n, hull_last, !busy, "busy with final result")
	`MCH_ASSERT_IMPL(a_count_cap, clk, arst_n, 1'b1,
		count_q <= mch_pkg::CNT_BITS'(mch_pkg::MAX_POINTS), "point count over cap")
	`MCH_ASSERT_IMPL(a_stack_cap, clk, arst_n, 1'b1,
		top_q <= mch_pkg::TOP_BITS'(mch_pkg::STK_DEPTH), "stack over depth")
endmodule
